// File: rtl/ff3_pkg.sv
`timescale 1ns / 1ps
package ff3_pkg;

  localparam int ROUNDS     = 8;
  localparam int MAX_BITS   = 48;
  localparam int HALF_BITS  = 24;
  localparam int AES_ROUNDS = 10;

  // Configuration register indexes.
  localparam logic CFG_KEY_HIGH = 1'b0;
  localparam logic CFG_KEY_LOW  = 1'b1;

  typedef logic [15:0][7:0] aes_state_t;

  typedef struct packed {
    logic                 err;
    logic                 dec;
    logic [4:0]           u;
    logic [4:0]           v;
    logic [HALF_BITS-1:0] a;
    logic [HALF_BITS-1:0] b;
    logic [63:0]          tweak;
  } item_t;

  localparam logic [7:0] RCON [AES_ROUNDS] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] xtime(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [HALF_BITS-1:0] rev_half(logic [HALF_BITS-1:0] x);
    logic [HALF_BITS-1:0] r;
    for (int k = 0; k < HALF_BITS; k++) r[k] = x[HALF_BITS-1-k];
    return r;
  endfunction

  function automatic logic [HALF_BITS-1:0] half_mask(logic [4:0] m);
    logic [HALF_BITS:0] one_hot;
    one_hot = (HALF_BITS+1)'(1) << m;
    return HALF_BITS'(one_hot - (HALF_BITS+1)'(1));
  endfunction

  // One AES round: SubBytes, ShiftRows, MixColumns unless last, AddRoundKey.
  function automatic aes_state_t aes_round(aes_state_t s, aes_state_t rk, logic last);
    aes_state_t o, t, mx;
    logic [7:0] a0, a1, a2, a3, tt;
    for (int k = 0; k < 16; k++) o[k] = SBOX[s[k]];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[r + 4*c] = o[r + 4*((c + r) % 4)];
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c];
      a1 = t[4*c+1];
      a2 = t[4*c+2];
      a3 = t[4*c+3];
      tt = a0 ^ a1 ^ a2 ^ a3;
      mx[4*c]   = a0 ^ tt ^ xtime(a0 ^ a1);
      mx[4*c+1] = a1 ^ tt ^ xtime(a1 ^ a2);
      mx[4*c+2] = a2 ^ tt ^ xtime(a2 ^ a3);
      mx[4*c+3] = a3 ^ tt ^ xtime(a3 ^ a0);
    end
    return (last ? t : mx) ^ rk;
  endfunction

  function automatic aes_state_t key_step(aes_state_t p, logic [7:0] rc);
    aes_state_t n;
    n[0] = p[0] ^ SBOX[p[13]] ^ rc;
    n[1] = p[1] ^ SBOX[p[14]];
    n[2] = p[2] ^ SBOX[p[15]];
    n[3] = p[3] ^ SBOX[p[12]];
    for (int k = 4; k < 16; k++) n[k] = p[k] ^ n[k-4];
    return n;
  endfunction

endpackage

// File: rtl/ff3_msg_if.sv
`timescale 1ns / 1ps
interface ff3_msg_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [5:0]  msg_bits;
  logic [47:0] message;
  logic [63:0] tweak_value;

  modport source (output valid, kind, msg_bits, message, tweak_value, input ready);
  modport sink (input valid, kind, msg_bits, message, tweak_value, output ready);
endinterface

// File: rtl/ff3_res_if.sv
`timescale 1ns / 1ps
interface ff3_res_if;
  logic        valid;
  logic        ready;
  logic [47:0] result;
  logic        length_error;

  modport source (output valid, result, length_error, input ready);
  modport sink (input valid, result, length_error, output ready);
endinterface

// File: rtl/ff3_binary_fpe_cipher_core.sv
`timescale 1ns / 1ps
// FF3 format-preserving cipher for binary messages of up to 48 bits.
// msg_ch takes one item per cycle while msg_ch.ready is high: direction,
// length, message and tweak. res_ch returns one item per input, in order: the
// result of the same length, or zero with length_error set when the length is
// above 48. The key is written through cfg_we/cfg_index/cfg_data (index 0 is
// the upper 64 bits, index 1 the lower); the user must write it only while no
// items are in flight, as the block does not enforce it. The datapath is fully
// unrolled: an input register, a half-split stage, then eight Feistel rounds of
// ten AES stages each, and an output register. While msg_ch.ready is high, a
// new item can be accepted every cycle. The round keys come from a registered
// chain of ten key-expansion steps that follows the key registers.
// Reset clears the key and all valid bits; the result registers are not reset.
// When the receiver stalls, the result holds and one more result lands in a
// skid register; msg_ch.ready then drops and the whole pipeline holds until
// the skid register drains, so nothing is lost or repeated.
module ff3_binary_fpe_cipher_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  ff3_msg_if.sink     msg_ch,
  ff3_res_if.source   res_ch
);
  import ff3_pkg::*;

  localparam int STAGES = ROUNDS * AES_ROUNDS;

  logic [63:0] key_high, key_low;
  aes_state_t  rk [AES_ROUNDS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_HIGH: key_high <= cfg_data;
        CFG_KEY_LOW:  key_low  <= cfg_data;
        default:      ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      rk[0][k]   = key_high[63 - 8*k -: 8];
      rk[0][k+8] = key_low[63 - 8*k -: 8];
    end
  end

  // Each round key is registered from the one before it, so it settles in the cycle after that one.
  for (genvar g = 1; g <= AES_ROUNDS; g++) begin : g_key
    always_ff @(posedge clk) rk[g] <= key_step(rk[g-1], RCON[g-1]);
  end

  logic adv;
  logic skid_v;
  assign adv = !skid_v;
  assign msg_ch.ready = adv;

  // Input register.
  logic        in_v;
  logic        in_kind;
  logic [5:0]  in_bits;
  logic [47:0] in_msg;
  logic [63:0] in_tweak;

  always_ff @(posedge clk) begin
    if (rst) in_v <= 1'b0;
    else if (adv) in_v <= msg_ch.valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_kind  <= msg_ch.kind;
      in_bits  <= msg_ch.msg_bits;
      in_msg   <= msg_ch.message;
      in_tweak <= msg_ch.tweak_value;
    end
  end

  // Split into halves and bit-reverse each.
  item_t       prep;
  logic [5:0]  n_eff;
  logic [48:0] n_mask;
  logic [47:0] msg_m, msg_hi;

  always_comb begin
    prep.err   = in_bits > 6'(MAX_BITS);
    prep.dec   = in_kind;
    prep.tweak = in_tweak;
    n_eff      = prep.err ? 6'd0 : in_bits;
    prep.v     = n_eff[5:1];
    prep.u     = 5'(n_eff - {1'b0, n_eff[5:1]});
    n_mask     = (49'(1) << n_eff) - 49'(1);
    msg_m      = in_msg & n_mask[47:0];
    msg_hi     = msg_m >> prep.v;
    prep.a     = rev_half(msg_hi[HALF_BITS-1:0]) >> (5'(HALF_BITS) - prep.u);
    prep.b     = rev_half(msg_m[HALF_BITS-1:0] & half_mask(prep.v))
                 >> (5'(HALF_BITS) - prep.v);
  end

  logic       pv  [STAGES+1];
  item_t      pit [STAGES+1];
  aes_state_t pst [STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) pv[0] <= 1'b0;
    else if (adv) pv[0] <= in_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pit[0] <= prep;
      pst[0] <= '0;
    end
  end

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    localparam int FI = g / AES_ROUNDS;
    localparam int AJ = g % AES_ROUNDS;

    logic [2:0]           rnd;
    logic [31:0]          word;
    logic [HALF_BITS-1:0] half, y, msk, c;
    logic [4:0]           m;
    aes_state_t           blk, s_in, s_out;
    item_t                nx;

    always_comb begin
      nx   = pit[g];
      rnd  = nx.dec ? 3'(ROUNDS - 1 - FI) : 3'(FI);
      word = rnd[0] ? nx.tweak[63:32] : nx.tweak[31:0];
      half = nx.dec ? nx.a : nx.b;
      blk  = '0;
      blk[0]  = word[31:24];
      blk[1]  = word[23:16];
      blk[2]  = word[15:8];
      blk[3]  = word[7:0] ^ {5'b0, rnd};
      blk[13] = half[23:16];
      blk[14] = half[15:8];
      blk[15] = half[7:0];
      s_in  = (AJ == 0) ? (blk ^ rk[0]) : pst[g];
      s_out = aes_round(s_in, rk[AJ+1], AJ == AES_ROUNDS - 1);
      y     = {s_out[2], s_out[1], s_out[0]};
      m     = rnd[0] ? nx.v : nx.u;
      msk   = half_mask(m);
      c     = '0;
      if (AJ == AES_ROUNDS - 1) begin
        if (!nx.dec) begin
          c    = (nx.a + y) & msk;
          nx.a = nx.b;
          nx.b = c;
        end else begin
          c    = (nx.b - y) & msk;
          nx.b = nx.a;
          nx.a = c;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) pv[g+1] <= 1'b0;
      else if (adv) pv[g+1] <= pv[g];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pit[g+1] <= nx;
        pst[g+1] <= s_out;
      end
    end
  end

  // Undo the bit reversal and join the halves.
  item_t                fin;
  logic [HALF_BITS-1:0] ra, rb;
  logic [47:0]          fin_res;

  always_comb begin
    fin     = pit[STAGES];
    ra      = rev_half(fin.a) >> (5'(HALF_BITS) - fin.u);
    rb      = rev_half(fin.b) >> (5'(HALF_BITS) - fin.v);
    fin_res = fin.err ? 48'd0 : (({24'd0, ra} << fin.v) | {24'd0, rb});
  end

  logic        o_v;
  logic [47:0] o_res;
  logic        o_err;
  logic [47:0] skid_res;
  logic        skid_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v    <= 1'b0;
      skid_v <= 1'b0;
    end else if (o_v && !res_ch.ready) begin
      if (adv && pv[STAGES]) skid_v <= 1'b1;
    end else if (skid_v) begin
      o_v    <= 1'b1;
      skid_v <= 1'b0;
    end else begin
      o_v <= pv[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (o_v && !res_ch.ready) begin
      if (adv && pv[STAGES]) begin
        skid_res <= fin_res;
        skid_err <= fin.err;
      end
    end else if (skid_v) begin
      o_res <= skid_res;
      o_err <= skid_err;
    end else begin
      o_res <= fin_res;
      o_err <= fin.err;
    end
  end

  assign res_ch.valid        = o_v;
  assign res_ch.result       = o_res;
  assign res_ch.length_error = o_err;

endmodule

// File: rtl/ff3_chk.sv
`timescale 1ns / 1ps
module ff3_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [47:0] result,
  input logic        length_error
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result) && $stable(length_error))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && length_error |-> result == 48'd0)
    else $error("error item carries a nonzero result");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("input held off without an output stall");

endmodule

bind ff3_binary_fpe_cipher_core ff3_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (msg_ch.ready),
  .out_valid    (res_ch.valid),
  .out_ready    (res_ch.ready),
  .result       (res_ch.result),
  .length_error (res_ch.length_error)
);

// File: tb/ff3_binary_fpe_cipher_core_tb.sv
`timescale 1ns / 1ps
module ff3_binary_fpe_cipher_core_tb;
  import ff3_pkg::*;

  localparam bit ENCRYPT      = 1'b0;
  localparam bit DECRYPT      = 1'b1;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    bit [47:0] result;
    bit        length_error;
  } cipher_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [63:0] cfg_data = '0;

  ff3_msg_if msg_ch ();
  ff3_res_if res_ch ();

  ff3_binary_fpe_cipher_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .msg_ch(msg_ch.sink), .res_ch(res_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bit [63:0]   key_hi, key_lo;
  bit [7:0]    sub_bytes [256];
  cipher_out_t pending_ciphers [$];
  int          errors, cycles, sent_items, checked_items, err_items, dec_items;
  int          send_idle_pct, recv_stall_pct, hold_request;

  // ---------------- predictor ----------------
  function automatic bit [7:0] gf_double(bit [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic bit [7:0] gf_mul(bit [7:0] a, bit [7:0] b);
    bit [7:0] r;
    r = 0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) r ^= a;
      a = gf_double(a);
    end
    return r;
  endfunction

  function automatic void build_sub_bytes();
    bit [7:0] inv, base, s;
    int e;
    for (int x = 0; x < 256; x++) begin
      inv = 8'd1;
      base = x[7:0];
      e = 254;
      if (x == 0) inv = 0;
      else while (e != 0) begin
        if (e & 1) inv = gf_mul(inv, base);
        base = gf_mul(base, base);
        e >>= 1;
      end
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sub_bytes[x] = s;
    end
  endfunction

  function automatic void expand_round_keys(output bit [7:0] w [176]);
    bit [7:0] t [4];
    bit [7:0] f, rc;
    rc = 8'h01;
    for (int i = 0; i < 8; i++) begin
      w[i]     = key_hi[63-8*i -: 8];
      w[8 + i] = key_lo[63-8*i -: 8];
    end
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) t[j] = w[i-4+j];
      if (i % 16 == 0) begin
        f = t[0];
        t[0] = sub_bytes[t[1]] ^ rc;
        t[1] = sub_bytes[t[2]];
        t[2] = sub_bytes[t[3]];
        t[3] = sub_bytes[f];
        rc = gf_double(rc);
      end
      for (int j = 0; j < 4; j++) w[i+j] = w[i-16+j] ^ t[j];
    end
  endfunction

  function automatic bit [63:0] round_pad(bit [7:0] w [176], bit [31:0] word, int rnd,
                                          bit [63:0] half);
    bit [7:0] s [16];
    bit [7:0] o [16];
    bit [7:0] a0, a1, a2, a3, tt;
    bit [63:0] y;
    for (int k = 0; k < 16; k++) s[k] = 0;
    s[0] = word[31:24];
    s[1] = word[23:16];
    s[2] = word[15:8];
    s[3] = word[7:0] ^ rnd[7:0];
    s[12] = half[31:24];
    s[13] = half[23:16];
    s[14] = half[15:8];
    s[15] = half[7:0];
    for (int k = 0; k < 16; k++) s[k] ^= w[k];
    for (int r = 1; r <= 10; r++) begin
      for (int k = 0; k < 16; k++) o[k] = sub_bytes[s[k]];
      for (int c = 0; c < 4; c++)
        for (int q = 0; q < 4; q++) s[q + 4*c] = o[q + 4*((c + q) % 4)];
      if (r != 10)
        for (int c = 0; c < 4; c++) begin
          a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
          tt = a0 ^ a1 ^ a2 ^ a3;
          s[4*c]   = a0 ^ tt ^ gf_double(a0 ^ a1);
          s[4*c+1] = a1 ^ tt ^ gf_double(a1 ^ a2);
          s[4*c+2] = a2 ^ tt ^ gf_double(a2 ^ a3);
          s[4*c+3] = a3 ^ tt ^ gf_double(a3 ^ a0);
        end
      for (int k = 0; k < 16; k++) s[k] ^= w[16*r + k];
    end
    y = 0;
    for (int k = 7; k >= 0; k--) y = (y << 8) | s[k];
    return y;
  endfunction

  function automatic bit [63:0] low_mask(int m);
    return (64'd1 << m) - 64'd1;
  endfunction

  function automatic bit [63:0] flip_bits(bit [63:0] x, int m);
    bit [63:0] r;
    r = 0;
    for (int k = 0; k < m; k++) r[m-1-k] = x[k];
    return r;
  endfunction

  function automatic cipher_out_t ff3_predict(bit dec, bit [5:0] n, bit [47:0] msg,
                                             bit [63:0] tw);
    cipher_out_t res;
    bit [7:0] w [176];
    bit [63:0] m_val, a, b, c, y;
    int u, v, m;
    if (n > MAX_BITS) begin
      res.result = 0;
      res.length_error = 1'b1;
      return res;
    end
    v = n / 2;
    u = n - v;
    m_val = {16'd0, msg} & low_mask(n);
    a = flip_bits(m_val >> v, u);
    b = flip_bits(m_val & low_mask(v), v);
    expand_round_keys(w);
    if (!dec) begin
      for (int r = 0; r < ROUNDS; r++) begin
        m = (r % 2) ? v : u;
        y = round_pad(w, (r % 2) ? tw[63:32] : tw[31:0], r, b);
        c = (a + y) & low_mask(m);
        a = b;
        b = c;
      end
    end else begin
      for (int r = ROUNDS - 1; r >= 0; r--) begin
        m = (r % 2) ? v : u;
        y = round_pad(w, (r % 2) ? tw[63:32] : tw[31:0], r, a);
        c = (b - y) & low_mask(m);
        b = a;
        a = c;
      end
    end
    res.result = 48'((flip_bits(a, u) << v) | flip_bits(b, v));
    res.length_error = 1'b0;
    return res;
  endfunction

  // ---------------- drivers ----------------
  initial begin
    msg_ch.valid = 1'b0;
    msg_ch.kind = 1'b0;
    msg_ch.msg_bits = '0;
    msg_ch.message = '0;
    msg_ch.tweak_value = '0;
    res_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random stalls, or one long hold-off counted down here.
  int hold_left;
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (rst) res_ch.ready <= 1'b0;
    else if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cipher_out_t exp_out;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_ciphers.size() == 0) begin
        $error("result item with no expectation: result=%h length_error=%b",
               res_ch.result, res_ch.length_error);
        errors++;
      end else begin
        exp_out = pending_ciphers.pop_front();
        checked_items++;
        if (res_ch.result !== exp_out.result) begin
          $error("result: expected %h, actual %h", exp_out.result, res_ch.result);
          errors++;
        end
        if (res_ch.length_error !== exp_out.length_error) begin
          $error("length_error: expected %b, actual %b", exp_out.length_error,
                 res_ch.length_error);
          errors++;
        end
      end
    end
  end

  task automatic send_msg(bit kind, bit [5:0] n, bit [47:0] msg, bit [63:0] tw);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      msg_ch.valid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    msg_ch.valid = 1'b1;
    msg_ch.kind = kind;
    msg_ch.msg_bits = n;
    msg_ch.message = msg;
    msg_ch.tweak_value = tw;
    forever begin
      @(posedge clk);
      if (msg_ch.ready) break;
    end
    pending_ciphers.push_back(ff3_predict(kind, n, msg, tw));
    sent_items++;
    if (n > MAX_BITS) err_items++;
    if (kind == DECRYPT) dec_items++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    msg_ch.valid = 1'b0;
  endtask

  task automatic write_reg(bit idx, bit [63:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    if (idx == CFG_KEY_HIGH) key_hi = data;
    else key_lo = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_ciphers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic bit [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_random_msg();
    bit [5:0] n;
    bit [63:0] tw;
    case ($urandom_range(9))
      0: n = 6'($urandom_range(63));
      1: n = $urandom_range(1) ? 6'd48 : 6'd2;
      default: n = 6'($urandom_range(48, 2));
    endcase
    case ($urandom_range(9))
      0: tw = '0;
      1: tw = '1;
      default: tw = rand64();
    endcase
    send_msg(1'($urandom_range(1)), n, 48'(rand64()), tw);
  endtask

  // ---------------- tests ----------------
  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // Extreme lengths, including zero, one and the too-long ones.
    send_msg(ENCRYPT, 6'd0, '1, '0);
    send_msg(DECRYPT, 6'd1, '1, '1);
    send_msg(ENCRYPT, 6'd2, 48'h3, '0);
    send_msg(DECRYPT, 6'd2, 48'h0, '1);
    send_msg(ENCRYPT, 6'd3, 48'h5, 64'h0123_4567_89ab_cdef);
    send_msg(ENCRYPT, 6'd47, '1, 64'hffff_ffff_0000_0000);
    send_msg(DECRYPT, 6'd47, '0, 64'h0000_0000_ffff_ffff);
    send_msg(ENCRYPT, 6'd48, '1, '1);
    send_msg(ENCRYPT, 6'd48, '0, '0);
    send_msg(DECRYPT, 6'd48, '1, '0);
    send_msg(DECRYPT, 6'd48, 48'h5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    send_msg(ENCRYPT, 6'd49, '1, '1);
    send_msg(DECRYPT, 6'd63, '1, '1);
    send_msg(ENCRYPT, 6'd56, 48'h1234, '0);
    // Bits above the length must not matter.
    send_msg(ENCRYPT, 6'd10, 48'hffff_ffff_fc00, 64'h5555_5555_5555_5555);
    send_msg(ENCRYPT, 6'd10, 48'h0000_0000_0000, 64'h5555_5555_5555_5555);
    send_msg(DECRYPT, 6'd24, 48'habcd_ef12_3456, 64'hdead_beef_cafe_f00d);
    send_msg(ENCRYPT, 6'd25, 48'h0001_ffff_ffff, 64'hdead_beef_cafe_f00d);
    stop_sending();
    wait_drained();
  endtask

  task automatic run_random_phase(int items, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (items) send_random_msg();
    stop_sending();
    wait_drained();
  endtask

  task automatic test_keys_and_idling();
    write_reg(CFG_KEY_HIGH, '1);
    write_reg(CFG_KEY_LOW, '1);
    run_random_phase(200, 0, 0);
    write_reg(CFG_KEY_HIGH, rand64());
    write_reg(CFG_KEY_LOW, rand64());
    run_random_phase(150, 79, 0);
    write_reg(CFG_KEY_HIGH, '0);
    write_reg(CFG_KEY_LOW, '1);
    run_random_phase(150, 0, 79);
    write_reg(CFG_KEY_HIGH, 64'h2b7e_1516_28ae_d2a6);
    write_reg(CFG_KEY_LOW, 64'habf7_1588_09cf_4f3c);
    run_random_phase(200, 25, 25);
  endtask

  task automatic test_backpressure();
    write_reg(CFG_KEY_HIGH, rand64());
    write_reg(CFG_KEY_LOW, rand64());
    send_idle_pct = 0;
    recv_stall_pct = 10;
    @(negedge clk);
    hold_request = 400;
    repeat (150) send_random_msg();
    stop_sending();
    wait_drained();
  endtask

  initial begin
    build_sub_bytes();
    key_hi = 0;
    key_lo = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_keys_and_idling();
    test_backpressure();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d messages (%0d decrypt, %0d over-length), %0d results checked,",
             sent_items, dec_items, err_items, checked_items);
    $display("across six keys, four idle/stall mixes and one long output hold-off.");
    if (errors == 0 && pending_ciphers.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
